@@ design/asymmetric_extremum_chunker_defines.svh @@
// Assertion macros shared by the chunker modules
`ifndef ASYMMETRIC_EXTREMUM_CHUNKER_DEFINES_SVH
`define ASYMMETRIC_EXTREMUM_CHUNKER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define AEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/aec_pkg.sv @@
// Types and constants of the asymmetric extremum chunker
package aec_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OUT_POS_W   = 48;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned WIN_W       = 16;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd256;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  typedef enum logic {
    OP_BYTE,
    OP_EOS
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic                 has_chunk;
    logic [CNT_W-1:0]     chunk_index;
    logic [OUT_POS_W-1:0] begin_pos;
    logic [OUT_POS_W-1:0] end_pos;
    logic                 is_final;
    logic [CNT_W-1:0]     total_chunks;
    logic [OUT_POS_W-1:0] stream_length;
  } res_t;

endpackage

@@ design/aec_front.sv @@
// Front end: takes input words and classifies them into queue operations
module aec_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_stream_i,
  output logic          op_valid_o,
  input  logic          op_ready_i,
  output aec_pkg::op_t  op_o
);
  import aec_pkg::*;

  logic valid_q, valid_d;
  op_t  op_q, op_d;
  logic take;

  assign in_ready_o = !valid_q || op_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    if (take) begin
      valid_d = 1'b1;
      op_d.kind = end_of_stream_i ? OP_EOS : OP_BYTE;
      op_d.data = end_of_stream_i ? 8'd0 : data_byte_i;
    end else if (op_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

@@ design/aec_fifo.sv @@
// Short operation queue between front and back
module aec_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  aec_pkg::op_t  push_op_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output aec_pkg::op_t  pop_op_o
);
  import aec_pkg::*;
  `include "asymmetric_extremum_chunker_defines.svh"

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  op_t              mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;
  logic push, pop;

  assign push_ready_o = count_q != CNT_QW'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  `AEC_ASSERT_NOW(a_fifo_bound, 1'b1, count_q <= CNT_QW'(QUEUE_DEPTH), "queue overfilled")
  `AEC_ASSERT_NEXT(a_fifo_track, push && !pop, count_q == $past(count_q) + 1'b1, "queue count lost a word")

endmodule

@@ design/aec_back.sv @@
// Back end: chunking state, cut decision and result register
module aec_back #(
  parameter int unsigned POS_WIDTH = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [aec_pkg::WIN_W-1:0]   cfg_window_width_i,
  input  logic                        op_valid_i,
  output logic                        op_ready_o,
  input  aec_pkg::op_t                op_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output aec_pkg::res_t               res_o
);
  import aec_pkg::*;
  `include "asymmetric_extremum_chunker_defines.svh"

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  function automatic logic [OUT_POS_W-1:0] out_pos(logic [POS_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_POS_W-1:0];
  endfunction

  logic [WIN_W-1:0]     window_q;
  logic [POS_WIDTH-1:0] byte_count_q, byte_count_d;
  logic [7:0]           max_value_q, max_value_d;
  logic [POS_WIDTH-1:0] max_pos_q, max_pos_d;
  logic [POS_WIDTH-1:0] chunk_begin_q, chunk_begin_d;
  logic [CNT_W-1:0]     chunk_counter_q, chunk_counter_d;
  logic                 chunk_open_q, chunk_open_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 res_q, res_d;

  logic                 take, sat, start, raise, cut;
  logic [POS_WIDTH-1:0] pos, ref_pos;
  logic [CNT_W-1:0]     cnt_inc;

  assign cfg_ready_o = 1'b1;
  assign op_ready_o  = !out_valid_q || out_ready_i;
  assign take        = op_valid_i && op_ready_o;

  assign sat     = byte_count_q == POS_MAX;
  assign pos     = sat ? POS_MAX - 1'b1 : byte_count_q;
  assign start   = !chunk_open_q;
  assign raise   = chunk_open_q && (op_i.data > max_value_q);
  assign ref_pos = start ? pos : max_pos_q;
  assign cut     = !raise && ((pos - ref_pos) == POS_WIDTH'(window_q));
  assign cnt_inc = (chunk_counter_q == CNT_MAX) ? CNT_MAX : chunk_counter_q + 1'b1;

  always_comb begin
    byte_count_d    = byte_count_q;
    max_value_d     = max_value_q;
    max_pos_d       = max_pos_q;
    chunk_begin_d   = chunk_begin_q;
    chunk_counter_d = chunk_counter_q;
    chunk_open_d    = chunk_open_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    res_d           = res_q;
    if (take) begin
      unique case (op_i.kind)
        OP_EOS: begin
          out_valid_d         = 1'b1;
          res_d.is_final      = 1'b1;
          res_d.stream_length = out_pos(byte_count_q);
          if (chunk_open_q) begin
            res_d.has_chunk    = 1'b1;
            res_d.chunk_index  = chunk_counter_q;
            res_d.begin_pos    = out_pos(chunk_begin_q);
            res_d.end_pos      = out_pos(byte_count_q - 1'b1);
            res_d.total_chunks = cnt_inc;
          end else begin
            res_d.has_chunk    = 1'b0;
            res_d.chunk_index  = '0;
            res_d.begin_pos    = '0;
            res_d.end_pos      = '0;
            res_d.total_chunks = chunk_counter_q;
          end
          byte_count_d    = '0;
          max_value_d     = '0;
          max_pos_d       = '0;
          chunk_begin_d   = '0;
          chunk_counter_d = '0;
          chunk_open_d    = 1'b0;
        end
        OP_BYTE: begin
          if (!sat) begin
            byte_count_d = byte_count_q + 1'b1;
          end
          if (cut) begin
            out_valid_d         = 1'b1;
            res_d.has_chunk     = 1'b1;
            res_d.chunk_index   = chunk_counter_q;
            res_d.begin_pos     = out_pos(start ? pos : chunk_begin_q);
            res_d.end_pos       = out_pos(pos);
            res_d.is_final      = 1'b0;
            res_d.total_chunks  = '0;
            res_d.stream_length = '0;
            chunk_counter_d     = cnt_inc;
            chunk_open_d        = 1'b0;
            max_value_d         = '0;
            max_pos_d           = '0;
            chunk_begin_d       = '0;
          end else if (start) begin
            chunk_open_d  = 1'b1;
            chunk_begin_d = pos;
            max_value_d   = op_i.data;
            max_pos_d     = pos;
          end else if (raise) begin
            max_value_d = op_i.data;
            max_pos_d   = pos;
          end
        end
        default: begin
          out_valid_d = out_valid_q && !out_ready_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q        <= WIN_RESET;
      byte_count_q    <= '0;
      max_value_q     <= '0;
      max_pos_q       <= '0;
      chunk_begin_q   <= '0;
      chunk_counter_q <= '0;
      chunk_open_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        window_q <= cfg_window_width_i;
      end
      byte_count_q    <= byte_count_d;
      max_value_q     <= max_value_d;
      max_pos_q       <= max_pos_d;
      chunk_begin_q   <= chunk_begin_d;
      chunk_counter_q <= chunk_counter_d;
      chunk_open_q    <= chunk_open_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  `AEC_ASSERT_NOW(a_cut_has_chunk, out_valid_q && !res_q.is_final, res_q.has_chunk, "cut word without chunk")
  `AEC_ASSERT_NEXT(a_eos_clears, take && op_i.kind == OP_EOS, byte_count_q == '0 && !chunk_open_q, "stream state not cleared")

endmodule

@@ design/asymmetric_extremum_chunker.sv @@
// Top level of the asymmetric extremum content-defined chunker
// Usage:
//  - Input channel (in_valid_i/in_ready_o) takes one word per cycle while in_ready_o is
//    high: a stream byte, or an end-of-stream marker when end_of_stream_i is high.
//  - Output channel (out_valid_o/out_ready_i) gives a word for every chunk cut and
//    one final word per end-of-stream marker with the stream totals.
//  - Config channel (cfg_valid_i/cfg_ready_o) sets the cut distance; always ready.
//    Write it only while the chunker is idle.
//  - Path: an input word passes the front register, the queue and the back result register;
//    the result is presented from that register and can be taken at the next edge.
//  - Throughput: one word per cycle unless a result waits with out_ready_i low; the
//    compare and subtract in the back end are combinational.
//  - Reset clears the stream state and sets the cut distance to 256.
//  - If the receiver stalls, the result register holds, the two-entry queue and the
//    front register fill, then in_ready_o drops; nothing is lost.
module asymmetric_extremum_chunker #(
  parameter int unsigned POS_WIDTH = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_window_width_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        has_chunk_o,
  output logic [31:0] chunk_index_o,
  output logic [47:0] begin_pos_o,
  output logic [47:0] end_pos_o,
  output logic        is_final_o,
  output logic [31:0] total_chunks_o,
  output logic [47:0] stream_length_o
);
  import aec_pkg::*;

  logic front_valid, front_ready, q_valid, q_ready;
  op_t  front_op, q_op;
  res_t res;

  aec_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .op_valid_o      (front_valid),
    .op_ready_i      (front_ready),
    .op_o            (front_op)
  );

  aec_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_op_i    (front_op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_op_o     (q_op)
  );

  aec_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_window_width_i (cfg_window_width_i),
    .op_valid_i         (q_valid),
    .op_ready_o         (q_ready),
    .op_i               (q_op),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .res_o              (res)
  );

  assign has_chunk_o     = res.has_chunk;
  assign chunk_index_o   = res.chunk_index;
  assign begin_pos_o     = res.begin_pos;
  assign end_pos_o       = res.end_pos;
  assign is_final_o      = res.is_final;
  assign total_chunks_o  = res.total_chunks;
  assign stream_length_o = res.stream_length;

endmodule
